// ===== rtl/csd_pkg.sv =====
// Shared types and constants for the CAN signal decoder.
package csd_pkg;

  localparam int FRAME_MAX_BYTES = 8;
  localparam int FRAME_W         = 64;
  localparam int PROD_W          = 96;   // 64 x 32 magnitude product
  localparam int SUM_W           = 98;   // signed product plus offset, exact

  // configuration register indexes
  localparam logic [2:0] CFG_START_POSITION = 3'd0;
  localparam logic [2:0] CFG_SIGNAL_LENGTH  = 3'd1;
  localparam logic [2:0] CFG_INTEL_ORDER    = 3'd2;
  localparam logic [2:0] CFG_SIGNED_RAW     = 3'd3;
  localparam logic [2:0] CFG_SCALE_FACTOR   = 3'd4;
  localparam logic [2:0] CFG_SCALE_OFFSET   = 3'd5;

  localparam logic [5:0]  RST_START_POSITION = 6'd0;
  localparam logic [6:0]  RST_SIGNAL_LENGTH  = 7'd8;
  localparam logic        RST_INTEL_ORDER    = 1'b1;
  localparam logic        RST_SIGNED_RAW     = 1'b0;
  localparam logic [31:0] RST_SCALE_FACTOR   = 32'h0001_0000;
  localparam logic [63:0] RST_SCALE_OFFSET   = 64'h0;

  localparam logic [6:0]  MAX_LENGTH = 7'd64;
  localparam logic [63:0] ONES64     = {64{1'b1}};
  localparam logic [63:0] PHYS_MAX   = {1'b0, {63{1'b1}}};
  localparam logic [63:0] PHYS_MIN   = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic [63:0] payload;
    logic [3:0]  payload_bytes;
  } in_t;

  typedef struct packed {
    logic [63:0]        raw_bits;
    logic signed [63:0] phys_value;
    logic               value_saturated;
  } out_t;

  typedef struct packed {
    logic [5:0]         start_position;
    logic [6:0]         signal_length;
    logic               intel_order;
    logic               signed_raw;
    logic signed [31:0] scale_factor;
    logic signed [63:0] scale_offset;
  } cfg_t;

  // extracted signal, split into sign and magnitudes ready for the multiplier
  typedef struct packed {
    logic [63:0] raw;
    logic [63:0] mag;
    logic [31:0] fmag;
    logic        neg;
  } gather_t;

endpackage

// ===== rtl/csd_extract.sv =====
// Bit extraction in Intel or Motorola layout, sign extension and magnitude split.
module csd_extract #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  csd_pkg::in_t     item,
  input  csd_pkg::cfg_t    cfg,
  output logic             out_valid,
  output csd_pkg::gather_t gather
);

  localparam logic [3:0] BYTE_LIMIT = 4'(PAYLOAD_BYTES);

  logic [3:0]  nb;
  logic [6:0]  len;
  logic [63:0] lmask;
  logic [63:0] pm;
  logic [63:0] pr;
  logic [63:0] raw_intel;
  logic [5:0]  m0;
  logic [6:0]  avail;
  logic [6:0]  room;
  logic [6:0]  cnt;
  logic [6:0]  span_end;
  logic [6:0]  sh;
  logic [63:0] cmask;
  logic [63:0] raw_moto;
  logic [63:0] raw_sel;
  logic [5:0]  sign_idx;
  logic        extend;
  logic [63:0] raw_x;
  logic        rneg;
  logic        fneg;
  csd_pkg::gather_t gather_next;

  assign nb  = (item.payload_bytes > BYTE_LIMIT) ? BYTE_LIMIT : item.payload_bytes;
  assign len = (cfg.signal_length > csd_pkg::MAX_LENGTH) ? csd_pkg::MAX_LENGTH
                                                         : cfg.signal_length;
  // shift by 64 yields zero, so length 64 gives all ones
  assign lmask = ~(csd_pkg::ONES64 << len);

  // zero the bytes past the frame end, and build the byte-reversed copy
  always_comb begin
    for (int k = 0; k < csd_pkg::FRAME_MAX_BYTES; k++) begin
      pm[8*k +: 8] = (4'(k) < nb) ? item.payload[8*k +: 8] : 8'h00;
    end
    for (int k = 0; k < csd_pkg::FRAME_MAX_BYTES; k++) begin
      pr[8*k +: 8] = pm[8*(csd_pkg::FRAME_MAX_BYTES-1-k) +: 8];
    end
  end

  assign raw_intel = (pm >> cfg.start_position) & lmask;

  // Motorola: walk index = byte*8 + (7 - bit) rises by one per signal bit.
  // Bits in missing bytes form a tail and are dropped, not zero-filled.
  assign m0       = {cfg.start_position[5:3], ~cfg.start_position[2:0]};
  assign avail    = {nb[3:0], 3'b000};
  assign room     = avail - {1'b0, m0};
  assign cnt      = (avail <= {1'b0, m0}) ? 7'd0 : ((len < room) ? len : room);
  assign span_end = {1'b0, m0} + cnt;
  assign sh       = csd_pkg::MAX_LENGTH - span_end;
  assign cmask    = ~(csd_pkg::ONES64 << cnt);
  assign raw_moto = (pr >> sh) & cmask;

  assign raw_sel  = cfg.intel_order ? raw_intel : raw_moto;

  assign sign_idx = 6'(len - 7'd1);
  assign extend   = cfg.signed_raw && (len != 7'd0) && (len != csd_pkg::MAX_LENGTH)
                    && raw_sel[sign_idx];
  assign raw_x    = extend ? (raw_sel | ~lmask) : raw_sel;
  assign rneg     = cfg.signed_raw & raw_x[63];
  assign fneg     = cfg.scale_factor[31];

  always_comb begin
    gather_next.raw  = raw_x;
    gather_next.mag  = rneg ? (~raw_x + 64'd1) : raw_x;
    gather_next.fmag = fneg ? (~cfg.scale_factor + 32'd1) : cfg.scale_factor;
    gather_next.neg  = rneg ^ fneg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    gather <= gather_next;
  end

endmodule

// ===== rtl/csd_scale.sv =====
// Fixed-point scaling: magnitude product, signed offset add and saturation.
module csd_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  csd_pkg::gather_t gather,
  input  csd_pkg::cfg_t    cfg,
  output logic             out_valid,
  output csd_pkg::out_t    result
);

  // stage: two 32 x 32 partial products
  logic        v_mul;
  logic [63:0] p0;
  logic [63:0] p1;
  logic [63:0] raw_mul;
  logic        neg_mul;

  // stage: merged magnitude product
  logic                       v_prod;
  logic [csd_pkg::PROD_W-1:0] prod;
  logic [63:0]                raw_prod;
  logic                       neg_prod;

  logic [csd_pkg::PROD_W-1:0] prod_next;
  logic [csd_pkg::SUM_W-1:0]  prod_ext;
  logic [csd_pkg::SUM_W-1:0]  opnd;
  logic [csd_pkg::SUM_W-1:0]  off_ext;
  logic [csd_pkg::SUM_W-1:0]  sum;
  logic                       fits;
  csd_pkg::out_t              result_next;

  always_ff @(posedge clk) begin
    p0      <= gather.mag[31:0]  * gather.fmag;
    p1      <= gather.mag[63:32] * gather.fmag;
    raw_mul <= gather.raw;
    neg_mul <= gather.neg;
  end

  assign prod_next = {32'd0, p0} + {p1, 32'd0};

  always_ff @(posedge clk) begin
    prod     <= prod_next;
    raw_prod <= raw_mul;
    neg_prod <= neg_mul;
  end

  // offset - prod is formed as offset + ~prod + 1; a zero product stays exact
  assign prod_ext = {{(csd_pkg::SUM_W-csd_pkg::PROD_W){1'b0}}, prod};
  assign opnd     = neg_prod ? ~prod_ext : prod_ext;
  assign off_ext  = {{(csd_pkg::SUM_W-64){cfg.scale_offset[63]}}, cfg.scale_offset};
  assign sum      = opnd + off_ext + {{(csd_pkg::SUM_W-1){1'b0}}, neg_prod};
  assign fits     = (sum[csd_pkg::SUM_W-1:63] == {(csd_pkg::SUM_W-63){1'b0}})
                 || (sum[csd_pkg::SUM_W-1:63] == {(csd_pkg::SUM_W-63){1'b1}});

  always_comb begin
    result_next.raw_bits        = raw_prod;
    result_next.value_saturated = ~fits;
    if (fits) begin
      result_next.phys_value = sum[63:0];
    end else begin
      result_next.phys_value = sum[csd_pkg::SUM_W-1] ? csd_pkg::PHYS_MIN
                                                      : csd_pkg::PHYS_MAX;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul     <= 1'b0;
      v_prod    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v_mul     <= in_valid;
      v_prod    <= v_mul;
      out_valid <= v_prod;
    end
  end

endmodule

// ===== rtl/can_signal_decoder_top.sv =====
// Top level of the CAN signal decoder: configuration registers and input stage.
//
// Decodes one configured signal from each CAN frame: start with the frame on
// request; after the input register, the extraction stage, the two-step 64 x 32
// multiplier and the offset add / saturation stage feeding the result register,
// done pulses for one cycle with raw_bits, phys_value and value_saturated on
// result. A new frame may start in every cycle (busy stays low), so one
// transaction per clock is sustained.
// The result is not held: the receiver must take it in the cycle done is high.
// Configuration is written through cfg_we / cfg_index / cfg_data and must be
// changed only when no frame is in flight.
module can_signal_decoder_top #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  csd_pkg::in_t  request,
  output logic          done,
  output csd_pkg::out_t result,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data
);

  csd_pkg::cfg_t    cfg;
  logic             v_in;
  csd_pkg::in_t     item;
  logic             v_gather;
  csd_pkg::gather_t gather;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_position <= csd_pkg::RST_START_POSITION;
      cfg.signal_length  <= csd_pkg::RST_SIGNAL_LENGTH;
      cfg.intel_order    <= csd_pkg::RST_INTEL_ORDER;
      cfg.signed_raw     <= csd_pkg::RST_SIGNED_RAW;
      cfg.scale_factor   <= csd_pkg::RST_SCALE_FACTOR;
      cfg.scale_offset   <= csd_pkg::RST_SCALE_OFFSET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csd_pkg::CFG_START_POSITION: cfg.start_position <= cfg_data[5:0];
        csd_pkg::CFG_SIGNAL_LENGTH:  cfg.signal_length  <= cfg_data[6:0];
        csd_pkg::CFG_INTEL_ORDER:    cfg.intel_order    <= cfg_data[0];
        csd_pkg::CFG_SIGNED_RAW:     cfg.signed_raw     <= cfg_data[0];
        csd_pkg::CFG_SCALE_FACTOR:   cfg.scale_factor   <= cfg_data[31:0];
        csd_pkg::CFG_SCALE_OFFSET:   cfg.scale_offset   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else begin
      v_in <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    item <= request;
  end

  csd_extract #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_extract (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v_in),
    .item     (item),
    .cfg      (cfg),
    .out_valid(v_gather),
    .gather   (gather)
  );

  csd_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v_gather),
    .gather   (gather),
    .cfg      (cfg),
    .out_valid(done),
    .result   (result)
  );

endmodule

// ===== verif/tb_can_signal_decoder_top.sv =====
// Self-checking testbench for the CAN signal decoder: directed table, then random traffic.
module tb_can_signal_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_TARGET = 1450;
  localparam int SETTLE       = 8;   // pipeline is five deep

  typedef enum logic {ROW_WRITE, ROW_FRAME} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic [2:0]    index;
    logic [63:0]   data;
    csd_pkg::in_t  frame;
    logic          known;
    csd_pkg::out_t want;
  } row_t;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  csd_pkg::in_t  request;
  logic          done;
  csd_pkg::out_t result;
  logic          cfg_we;
  logic [2:0]    cfg_index;
  logic [63:0]   cfg_data;

  csd_pkg::cfg_t shadow_cfg;
  csd_pkg::out_t pending_decodes[$];
  row_t          plan[$];
  logic          use_known;
  csd_pkg::out_t known_result;
  logic          steady;
  int            fault_count;
  int            frames_sent;

  can_signal_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  // Bit-exact decode of one frame under the given register set.
  function automatic csd_pkg::out_t predict_decode(csd_pkg::in_t f, csd_pkg::cfg_t c);
    logic [63:0]   raw;
    logic [129:0]  wide_raw;
    logic [129:0]  wide_sum;
    logic          neg;
    int            nbytes;
    int            len;
    int            pos;
    int            i;
    csd_pkg::out_t o;
    nbytes = (f.payload_bytes > csd_pkg::FRAME_MAX_BYTES) ? csd_pkg::FRAME_MAX_BYTES
                                                          : int'(f.payload_bytes);
    len    = (c.signal_length > csd_pkg::MAX_LENGTH) ? 64 : int'(c.signal_length);
    raw    = '0;
    pos    = c.start_position;
    for (i = 0; i < len; i++) begin
      if (c.intel_order) begin
        if (pos + i < 64 && ((pos + i) >> 3) < nbytes) raw[i] = f.payload[pos + i];
      end else begin
        // out-of-frame bits are dropped, not shifted in as zero
        if (pos < 64 && (pos >> 3) < nbytes) raw = {raw[62:0], f.payload[pos]};
        pos = (pos % 8 == 0) ? pos + 15 : pos - 1;
      end
    end
    neg = 1'b0;
    if (c.signed_raw && len > 0) begin
      if (len < 64 && raw[len-1]) raw = raw | ~((64'd1 << len) - 64'd1);
      neg = raw[63];
    end
    wide_raw = neg ? {{66{1'b1}}, raw} : {66'd0, raw};
    wide_sum = wide_raw * {{98{c.scale_factor[31]}}, c.scale_factor}
             + {{66{c.scale_offset[63]}}, c.scale_offset};
    o.raw_bits = raw;
    if (wide_sum[129:63] == '0 || wide_sum[129:63] == '1) begin
      o.phys_value      = wide_sum[63:0];
      o.value_saturated = 1'b0;
    end else begin
      o.phys_value      = wide_sum[129] ? csd_pkg::PHYS_MIN : csd_pkg::PHYS_MAX;
      o.value_saturated = 1'b1;
    end
    return o;
  endfunction

  always @(posedge clk) begin : check_results
    csd_pkg::out_t want;
    if (!rst) begin
      if (start && !busy)
        pending_decodes = {pending_decodes,
                           use_known ? known_result : predict_decode(request, shadow_cfg)};
      if (done) begin
        if (pending_decodes.size() == 0) begin
          $error("result transaction with nothing expected: raw_bits %h", result.raw_bits);
          fault_count++;
        end else begin
          want = pending_decodes.pop_front();
          if (result.raw_bits !== want.raw_bits) begin
            $error("raw_bits: expected %h, got %h", want.raw_bits, result.raw_bits);
            fault_count++;
          end
          if (result.phys_value !== want.phys_value) begin
            $error("phys_value: expected %h, got %h",
                   want.phys_value, result.phys_value);
            fault_count++;
          end
          if (result.value_saturated !== want.value_saturated) begin
            $error("value_saturated: expected %b, got %b",
                   want.value_saturated, result.value_saturated);
            fault_count++;
          end
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_frame(input csd_pkg::in_t f, input logic known,
                            input csd_pkg::out_t want);
    int gap;
    gap = steady ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start        <= 1'b1;
    request      <= f;
    use_known    = known;
    known_result = want;
    do @(posedge clk); while (busy);
    frames_sent++;
  endtask

  // hold off until every outstanding transaction has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      csd_pkg::CFG_START_POSITION: shadow_cfg.start_position = value[5:0];
      csd_pkg::CFG_SIGNAL_LENGTH:  shadow_cfg.signal_length  = value[6:0];
      csd_pkg::CFG_INTEL_ORDER:    shadow_cfg.intel_order    = value[0];
      csd_pkg::CFG_SIGNED_RAW:     shadow_cfg.signed_raw     = value[0];
      csd_pkg::CFG_SCALE_FACTOR:   shadow_cfg.scale_factor   = value[31:0];
      csd_pkg::CFG_SCALE_OFFSET:   shadow_cfg.scale_offset   = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(input row_t r);
    plan = {plan, r};
  endtask

  function automatic row_t reg_row(logic [2:0] idx, logic [63:0] value);
    row_t r;
    r       = '{kind: ROW_WRITE, index: idx, data: value, default: '0};
    return r;
  endfunction

  function automatic row_t frame_row(logic [63:0] payload, logic [3:0] nbytes);
    row_t r;
    r       = '{kind: ROW_FRAME, default: '0};
    r.frame = '{payload: payload, payload_bytes: nbytes};
    return r;
  endfunction

  function automatic row_t known_row(logic [63:0] payload, logic [3:0] nbytes,
                                     logic [63:0] raw, logic [63:0] phys, logic sat);
    row_t r;
    r       = frame_row(payload, nbytes);
    r.known = 1'b1;
    r.want  = '{raw_bits: raw, phys_value: phys, value_saturated: sat};
    return r;
  endfunction

  function automatic csd_pkg::in_t random_frame();
    csd_pkg::in_t f;
    int           r;
    r = $urandom_range(0, 9);
    case (r)
      7:       f.payload = '0;
      8:       f.payload = csd_pkg::ONES64;
      9:       f.payload = {$urandom, $urandom} & {$urandom, $urandom};
      default: f.payload = {$urandom, $urandom};
    endcase
    r = $urandom_range(0, 9);
    if (r < 6)      f.payload_bytes = 4'd8;
    else if (r < 9) f.payload_bytes = 4'($urandom_range(0, 8));
    else            f.payload_bytes = 4'($urandom_range(9, 15));
    return f;
  endfunction

  task automatic program_phase(input int phase);
    logic [5:0]  sp;
    logic [6:0]  len;
    logic        intel;
    logic        sgn;
    logic [31:0] factor;
    logic [63:0] offset;
    sp    = 6'($urandom_range(0, 63));
    intel = 1'($urandom_range(0, 1));
    sgn   = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 8: len = 7'($urandom_range(1, 64));
      4, 5:          len = 7'($urandom_range(1, 16));
      6:             len = 7'd64;
      7:             len = 7'($urandom_range(65, 127));
      default:       len = 7'($urandom_range(0, 8));
    endcase
    case ($urandom_range(0, 6))
      0:       factor = csd_pkg::RST_SCALE_FACTOR;
      1:       factor = 32'h8000_0000;
      2:       factor = 32'h7FFF_FFFF;
      3:       factor = 32'($urandom_range(0, 1 << 17) * ($urandom_range(0, 1) ? 1 : -1));
      default: factor = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0:       offset = '0;
      1:       offset = csd_pkg::PHYS_MIN;
      2:       offset = csd_pkg::PHYS_MAX;
      3:       offset = 64'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      default: offset = {$urandom, $urandom};
    endcase
    if (phase == 0) begin
      sp = 6'd63; len = 7'd127; intel = 1'b1; sgn = 1'b1;
      factor = 32'h7FFF_FFFF; offset = csd_pkg::PHYS_MAX;
    end else if (phase == 1) begin
      sp = 6'd0; len = 7'd0; intel = 1'b0; sgn = 1'b0;
      factor = 32'h8000_0000; offset = csd_pkg::PHYS_MIN;
    end else if (phase == 2) begin
      sp = 6'd0; len = 7'd64; intel = 1'b1; sgn = 1'b1;
    end
    write_reg(csd_pkg::CFG_START_POSITION, {58'd0, sp});
    write_reg(csd_pkg::CFG_SIGNAL_LENGTH,  {57'd0, len});
    write_reg(csd_pkg::CFG_INTEL_ORDER,    {63'd0, intel});
    write_reg(csd_pkg::CFG_SIGNED_RAW,     {63'd0, sgn});
    write_reg(csd_pkg::CFG_SCALE_FACTOR,   {32'd0, factor});
    write_reg(csd_pkg::CFG_SCALE_OFFSET,   offset);
  endtask

  initial begin : stimulus
    logic writing;
    int   phase;
    int   n;
    start       = 1'b0;
    request     = '0;
    cfg_we      = 1'b0;
    cfg_index   = csd_pkg::CFG_START_POSITION;
    cfg_data    = '0;
    use_known   = 1'b0;
    known_result = '0;
    steady      = 1'b0;
    fault_count = 0;
    frames_sent = 0;
    shadow_cfg  = '{start_position: csd_pkg::RST_START_POSITION,
                    signal_length: csd_pkg::RST_SIGNAL_LENGTH,
                    intel_order: csd_pkg::RST_INTEL_ORDER,
                    signed_raw: csd_pkg::RST_SIGNED_RAW,
                    scale_factor: csd_pkg::RST_SCALE_FACTOR,
                    scale_offset: csd_pkg::RST_SCALE_OFFSET};
    rst = 1'b1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // register values straight after reset
    add_row(known_row(64'hA5, 4'd1, 64'hA5, 64'hA5_0000, 1'b0));
    add_row(known_row(csd_pkg::ONES64, 4'd0, 64'h0, 64'h0, 1'b0));
    add_row(known_row(csd_pkg::ONES64, 4'd15, 64'hFF, 64'hFF_0000, 1'b0));
    add_row(frame_row(64'h0123_4567_89AB_CDEF, 4'd8));
    // full-width signed with the most negative factor
    add_row(reg_row(csd_pkg::CFG_SIGNAL_LENGTH, 64'd64));
    add_row(reg_row(csd_pkg::CFG_SIGNED_RAW, 64'd1));
    add_row(reg_row(csd_pkg::CFG_SCALE_FACTOR, 64'h8000_0000));
    add_row(known_row(csd_pkg::PHYS_MIN, 4'd8, csd_pkg::PHYS_MIN, csd_pkg::PHYS_MAX, 1'b1));
    add_row(known_row(csd_pkg::ONES64, 4'd8, csd_pkg::ONES64, 64'h8000_0000, 1'b0));
    add_row(reg_row(csd_pkg::CFG_SIGNED_RAW, 64'd0));
    add_row(known_row(csd_pkg::ONES64, 4'd8, csd_pkg::ONES64, csd_pkg::PHYS_MIN, 1'b1));
    add_row(reg_row(csd_pkg::CFG_SCALE_FACTOR, 64'h7FFF_FFFF));
    add_row(known_row(csd_pkg::ONES64, 4'd8, csd_pkg::ONES64, csd_pkg::PHYS_MAX, 1'b1));
    // zero factor passes the offset straight through
    add_row(reg_row(csd_pkg::CFG_SCALE_FACTOR, 64'h0));
    add_row(reg_row(csd_pkg::CFG_SCALE_OFFSET, csd_pkg::PHYS_MAX));
    add_row(known_row(csd_pkg::ONES64, 4'd8, csd_pkg::ONES64, csd_pkg::PHYS_MAX, 1'b0));
    add_row(reg_row(csd_pkg::CFG_SCALE_FACTOR, 64'h1_0000));
    add_row(reg_row(csd_pkg::CFG_SCALE_OFFSET, csd_pkg::PHYS_MIN));
    add_row(reg_row(csd_pkg::CFG_SIGNED_RAW, 64'd1));
    add_row(known_row(csd_pkg::ONES64, 4'd8, csd_pkg::ONES64, csd_pkg::PHYS_MIN, 1'b1));
    add_row(reg_row(csd_pkg::CFG_SIGNAL_LENGTH, 64'd0));
    add_row(known_row(csd_pkg::ONES64, 4'd8, 64'h0, csd_pkg::PHYS_MIN, 1'b0));
    // oversized length clamps to 64
    add_row(reg_row(csd_pkg::CFG_SIGNAL_LENGTH, 64'd127));
    add_row(reg_row(csd_pkg::CFG_SCALE_OFFSET, 64'h0));
    add_row(reg_row(csd_pkg::CFG_SIGNED_RAW, 64'd0));
    add_row(frame_row(64'h0123_4567_89AB_CDEF, 4'd8));
    // Intel field running off the top of the frame
    add_row(reg_row(csd_pkg::CFG_START_POSITION, 64'd60));
    add_row(reg_row(csd_pkg::CFG_SIGNAL_LENGTH, 64'd12));
    add_row(reg_row(csd_pkg::CFG_SIGNED_RAW, 64'd1));
    add_row(frame_row(csd_pkg::ONES64, 4'd8));
    add_row(frame_row(csd_pkg::ONES64, 4'd4));
    // Motorola: byte 0 then byte 1, short frame drops the missing bits
    add_row(reg_row(csd_pkg::CFG_START_POSITION, 64'd7));
    add_row(reg_row(csd_pkg::CFG_SIGNAL_LENGTH, 64'd16));
    add_row(reg_row(csd_pkg::CFG_INTEL_ORDER, 64'd0));
    add_row(reg_row(csd_pkg::CFG_SIGNED_RAW, 64'd0));
    add_row(known_row(64'h3412, 4'd2, 64'h1234, 64'h1234_0000, 1'b0));
    add_row(known_row(64'h3412, 4'd1, 64'h12, 64'h12_0000, 1'b0));
    add_row(reg_row(csd_pkg::CFG_SIGNED_RAW, 64'd1));
    add_row(frame_row(64'h3492, 4'd1));
    add_row(frame_row(64'h3492, 4'd2));
    add_row(reg_row(csd_pkg::CFG_START_POSITION, 64'd63));
    add_row(reg_row(csd_pkg::CFG_SIGNAL_LENGTH, 64'd20));
    add_row(frame_row(64'hC3A5_0000_0000_0000, 4'd8));
    add_row(reg_row(csd_pkg::CFG_START_POSITION, 64'd0));
    add_row(reg_row(csd_pkg::CFG_SIGNAL_LENGTH, 64'd64));
    add_row(frame_row(64'h0123_4567_89AB_CDEF, 4'd8));

    writing = 1'b0;
    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) begin
        if (!writing) drain();
        write_reg(plan[k].index, plan[k].data);
        writing = 1'b1;
      end else begin
        writing = 1'b0;
        send_frame(plan[k].frame, plan[k].known, plan[k].want);
      end
    end

    phase = 0;
    while (frames_sent < FRAME_TARGET) begin
      drain();
      program_phase(phase);
      steady = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 120);
      if (n > FRAME_TARGET - frames_sent) n = FRAME_TARGET - frames_sent;
      repeat (n) begin
        if ($urandom_range(0, 149) == 0) drain();
        send_frame(random_frame(), 1'b0, '0);
      end
      phase++;
    end
    drain();

    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
